// File: hdl/stable_sorted_priority_queue_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Checked at every clock edge outside reset.
`define SSPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("priority queue assertion failed");

// Checked at every clock edge, reset included.
`define SSPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("priority queue assertion failed");

`endif

// File: hdl/sspq_pkg.sv
// Types and constants of the stable sorted priority queue.
package sspq_pkg;

   localparam int unsigned DEPTH   = 16;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned PRIO_W  = 15;
   localparam int unsigned REQ_PRIO_W = 16;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_BAD_PRIO = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_ENTRY    = 3'd3,
      STATUS_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
      logic signed [REQ_PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic signed [VALUE_W-1:0] entry_value;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } slot_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic     insert;
      logic     rotate;
      slot_type new_slot;
   } cell_ctrl_type;

endpackage

// File: hdl/stable_sorted_priority_queue.sv
// Stable sorted priority queue: control, response register and the chain of cells.
// An insert, or a read of an empty queue, gives one word in the cycle after acceptance.
// A read of n entries gives n words, the first once the state register is in drain,
// then one per cycle unless stalled, as occupied cells pass the head; next item waits.
// Back-to-back inserts are accepted every cycle while the response side moves.
// Reset (synchronous) empties the queue; cell contents are left as they are.
`include "stable_sorted_priority_queue_macros.svh"

module stable_sorted_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sspq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sspq_pkg::rsp_type rsp_data
);

   localparam sspq_pkg::cnt_type CountMax = sspq_pkg::cnt_type'(sspq_pkg::DEPTH);

   sspq_pkg::state_type     state_ff, state_in;
   sspq_pkg::cnt_type       count_ff, count_in;
   sspq_pkg::cnt_type       remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sspq_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                    out_free;
   logic                    accept;
   logic                    drain_step;
   logic                    prio_ok;
   logic                    full;
   logic                    in_drain;
   logic                    last_step;
   sspq_pkg::cell_ctrl_type ctrl;

   logic [sspq_pkg::DEPTH-1:0] ge;
   sspq_pkg::slot_type         slots [sspq_pkg::DEPTH];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign prio_ok  = !req_data.priority_req[sspq_pkg::REQ_PRIO_W-1] &&
                     (req_data.priority_req != '0);
   assign full     = (count_ff == sspq_pkg::cnt_type'(sspq_pkg::DEPTH));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sspq_pkg::ST_IDLE: begin
            if (accept && (req_data.kind == sspq_pkg::KIND_READ) && (count_ff != '0)) begin
               state_in = sspq_pkg::ST_DRAIN;
            end
         end
         sspq_pkg::ST_DRAIN: begin
            if (out_free && (remain_ff == sspq_pkg::cnt_type'(1))) begin
               state_in = sspq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sspq_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall  = 1'b1;
      drain_step = 1'b0;
      case (state_ff)
         sspq_pkg::ST_IDLE: begin
            req_stall = !out_free;
         end
         sspq_pkg::ST_DRAIN: begin
            drain_step = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign in_drain  = (state_ff == sspq_pkg::ST_DRAIN);
   assign last_step = drain_step && (remain_ff == sspq_pkg::cnt_type'(1));

   always_comb begin
      ctrl.insert = accept && (req_data.kind == sspq_pkg::KIND_INSERT) && prio_ok && !full;
      ctrl.rotate = drain_step;
      ctrl.new_slot.value = req_data.value;
      ctrl.new_slot.prio  = req_data.priority_req[sspq_pkg::PRIO_W-1:0];
   end

   always_comb begin
      count_in  = count_ff;
      remain_in = remain_ff;
      if (ctrl.insert) begin
         count_in = count_ff + sspq_pkg::cnt_type'(1);
      end
      if (accept && (req_data.kind == sspq_pkg::KIND_READ)) begin
         remain_in = count_ff;
      end else if (drain_step) begin
         remain_in = remain_ff - sspq_pkg::cnt_type'(1);
      end
   end

   // Response register: loaded on an insert, empty read or drain step, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_data_in.entry_value = '0;
         rsp_data_in.last        = 1'b1;
         if (req_data.kind == sspq_pkg::KIND_READ) begin
            rsp_valid_in       = (count_ff == '0);
            rsp_data_in.status = sspq_pkg::STATUS_EMPTY;
            if (count_ff != '0) begin
               rsp_data_in = rsp_data_ff;
            end
         end else begin
            rsp_valid_in = 1'b1;
            if (!prio_ok) begin
               rsp_data_in.status = sspq_pkg::STATUS_BAD_PRIO;
            end else if (full) begin
               rsp_data_in.status = sspq_pkg::STATUS_FULL;
            end else begin
               rsp_data_in.status = sspq_pkg::STATUS_INSERTED;
            end
         end
      end else if (drain_step) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = sspq_pkg::STATUS_ENTRY;
         rsp_data_in.entry_value = slots[0].value;
         rsp_data_in.last        = (remain_ff == sspq_pkg::cnt_type'(1));
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sspq_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < sspq_pkg::DEPTH; i++) begin : g_cell
      localparam sspq_pkg::cnt_type CellIdx  = sspq_pkg::cnt_type'(i);
      localparam sspq_pkg::cnt_type CellNext = sspq_pkg::cnt_type'(i + 1);

      logic               prev_ge;
      sspq_pkg::slot_type prev_slot;
      sspq_pkg::slot_type next_slot;

      if (i == 0) begin : g_first
         assign prev_ge   = 1'b1;
         assign prev_slot = ctrl.new_slot;
      end else begin : g_inner
         assign prev_ge   = ge[i-1];
         assign prev_slot = slots[i-1];
      end

      if (i == sspq_pkg::DEPTH - 1) begin : g_end
         assign next_slot = slots[0];
      end else begin : g_mid
         assign next_slot = slots[i+1];
      end

      sspq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (CellIdx < count_ff),
         .tail      (count_ff == CellNext),
         .prev_ge   (prev_ge),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .head_slot (slots[0]),
         .ge        (ge[i]),
         .slot      (slots[i])
      );
   end

   // The count is unknown before the first reset edge, so reset covers that edge.
   `SSPQ_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CountMax))
   `SSPQ_ASSERT(a_drain_remain, clock, reset, in_drain |-> (|remain_ff && (remain_ff <= count_ff)))
   `SSPQ_ASSERT(a_drain_end, clock, reset, last_step |=> !in_drain)
   `SSPQ_ASSERT(a_drain_count_hold, clock, reset, in_drain |=> $stable(count_ff))

endmodule

// File: hdl/sspq_cell.sv
// One storage cell of the sorted chain: holds a slot and moves it along the chain.
module sspq_cell (
   input  logic                   clock,
   input  sspq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   tail,
   input  logic                   prev_ge,
   input  sspq_pkg::slot_type     prev_slot,
   input  sspq_pkg::slot_type     next_slot,
   input  sspq_pkg::slot_type     head_slot,
   output logic                   ge,
   output sspq_pkg::slot_type     slot
);

   sspq_pkg::slot_type slot_ff;
   sspq_pkg::slot_type slot_in;

   // The new word goes behind every held entry of equal or lower priority number.
   assign ge   = occupied && (slot_ff.prio <= ctrl.new_slot.prio);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert) begin
         if (!ge) begin
            slot_in = prev_ge ? ctrl.new_slot : prev_slot;
         end
      end else if (ctrl.rotate && occupied) begin
         // The occupied part of the chain turns by one; the head wraps to the tail.
         slot_in = tail ? head_slot : next_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
